// ===== design/debounced_inputs_with_pulse_timers_top_macros.svh =====
// Assertion macros shared by the debounced inputs with pulse timers design.
`ifndef DEBOUNCED_INPUTS_WITH_PULSE_TIMERS_TOP_MACROS_SVH
`define DEBOUNCED_INPUTS_WITH_PULSE_TIMERS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define DIPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define DIPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/dipt_pkg.sv =====
// Types and constants for the debounced inputs with pulse timers block.
package dipt_pkg;

	localparam int CMD_W      = 3;
	localparam int RAW_W      = 2;
	localparam int CHAN_W     = 2;
	localparam int TICKS_W    = 24;
	localparam int DEB_W      = 16;
	localparam int CNT_W      = 16;
	localparam int PLS_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int S_DATA_W   = 32;
	localparam int M_DATA_W   = 32;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW     = 1'b1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK    = 3'd0,
		CMD_PULSE   = 3'd1,
		CMD_CLEAR   = 3'd2,
		CMD_ALL_OFF = 3'd3,
		CMD_INIT    = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [S_DATA_W-TICKS_W-CHAN_W-RAW_W-1:0] pad;
		logic [TICKS_W-1:0]                        pulse_ticks;
		logic [CHAN_W-1:0]                         pulse_channel;
		logic [RAW_W-1:0]                          raw_levels;
	} in_t;

	typedef struct packed {
		logic [M_DATA_W-PLS_W-CNT_W-2-2*RAW_W-1:0] pad;
		logic [PLS_W-1:0]                          pulse_levels;
		logic [CNT_W-1:0]                          response_count;
		logic                                      response_latch;
		logic                                      response_event;
		logic [RAW_W-1:0]                          edge_flags;
		logic [RAW_W-1:0]                          stable_levels;
	} res_t;

endpackage

// ===== design/debounced_inputs_with_pulse_timers_top.sv =====
// Debounced inputs with pulse timers: command stream in, status stream out.
//
// Channels: s_* carries commands (kind in s_tuser, operands in s_tdata),
// m_* carries one status word per command. cfg_* writes debounce_ticks
// (index 0) and active_low (index 1); write only while the block is idle.
// A command taken from s_* goes into the input stage; when it advances, the
// state and the result register update together and m_tvalid rises.
// The block takes one command per cycle while the receiver takes results;
// the debounce compare and count per input and the countdown per output all
// fit in one pass between the input stage and the result register.
// When the receiver stalls the result holds in the result register and one
// more command waits in the input stage; s_tready then drops until the
// result is taken.
// Reset clears all levels, counts, pulses and the latch, sets debounce_ticks
// to 1 and active_low to 0, and empties both stages.
`include "debounced_inputs_with_pulse_timers_top_macros.svh"

module debounced_inputs_with_pulse_timers_top
	import dipt_pkg::*;
#(
	parameter int NUM_INPUTS  = 2,
	parameter int NUM_OUTPUTS = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,  // raw_levels, pulse_channel, pulse_ticks, zero pad
	input  logic [CMD_W-1:0]      s_tuser,  // command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [M_DATA_W-1:0]   m_tdata,  // stable_levels, edge_flags, response_event,
	                                        // response_latch, response_count, pulse_levels, pad
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic                  valid_s1;
	cmd_t                  cmd_s1;
	in_t                   in_s1;
	logic                  adv;

	logic                  out_valid_q;
	res_t                  res_q;
	res_t                  res_d;

	logic [DEB_W-1:0]      deb_q;
	logic                  act_low_q;

	logic [NUM_INPUTS-1:0] cand_q, cand_d;
	logic [NUM_INPUTS-1:0] stable_q, stable_d;
	logic [DEB_W-1:0]      held_q [NUM_INPUTS];
	logic [DEB_W-1:0]      held_d [NUM_INPUTS];
	logic [TICKS_W-1:0]    pulse_q [NUM_OUTPUTS];
	logic [TICKS_W-1:0]    pulse_d [NUM_OUTPUTS];
	logic                  latch_q, latch_d;
	logic [CNT_W-1:0]      count_q, count_d;

	logic [NUM_INPUTS-1:0] raw_ext;
	logic [NUM_INPUTS-1:0] samp;
	logic [NUM_INPUTS-1:0] edge_d;
	logic                  event_d;
	logic [DEB_W-1:0]      limit;
	logic [NUM_OUTPUTS-1:0] pulse_on;
	logic [RAW_W-1:0]      stable_lo;
	logic [RAW_W-1:0]      edge_lo;
	logic [PLS_W-1:0]      pulse_lo;

	// handshake
	assign adv      = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_t'(s_tuser);
			in_s1  <= in_t'(s_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= adv | (out_valid_q & ~m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q     <= DEB_W'(1);
			act_low_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DEBOUNCE_TICKS: deb_q     <= cfg_wdata[DEB_W-1:0];
				REG_ACTIVE_LOW:     act_low_q <= cfg_wdata[0];
			endcase
		end
	end

	// width adaption between channel counts and fixed field widths
	generate
		if (NUM_INPUTS <= RAW_W) begin : g_raw_narrow
			assign raw_ext = in_s1.raw_levels[NUM_INPUTS-1:0];
		end else begin : g_raw_wide
			assign raw_ext = {{(NUM_INPUTS-RAW_W){1'b0}}, in_s1.raw_levels};
		end
		if (NUM_INPUTS >= RAW_W) begin : g_lvl_wide
			assign stable_lo = stable_d[RAW_W-1:0];
			assign edge_lo   = edge_d[RAW_W-1:0];
		end else begin : g_lvl_narrow
			assign stable_lo = {{(RAW_W-NUM_INPUTS){1'b0}}, stable_d};
			assign edge_lo   = {{(RAW_W-NUM_INPUTS){1'b0}}, edge_d};
		end
		if (NUM_OUTPUTS >= PLS_W) begin : g_pls_wide
			assign pulse_lo = pulse_on[PLS_W-1:0];
		end else begin : g_pls_narrow
			assign pulse_lo = {{(PLS_W-NUM_OUTPUTS){1'b0}}, pulse_on};
		end
	endgenerate

	assign samp  = raw_ext ^ {NUM_INPUTS{act_low_q}};
	assign limit = (deb_q == '0) ? DEB_W'(1) : deb_q;

	// next state for one command
	always_comb begin
		logic [DEB_W-1:0] h1;
		h1       = '0;
		cand_d   = cand_q;
		stable_d = stable_q;
		held_d   = held_q;
		pulse_d  = pulse_q;
		latch_d  = latch_q;
		count_d  = count_q;
		edge_d   = '0;
		event_d  = 1'b0;
		unique case (cmd_s1)
			CMD_TICK: begin
				for (int i = 0; i < NUM_INPUTS; i++) begin
					if (samp[i] != cand_q[i]) begin
						cand_d[i] = samp[i];
						held_d[i] = '0;
					end else if (samp[i] == stable_q[i]) begin
						held_d[i] = '0;
					end else begin
						h1 = held_q[i] + DEB_W'(1);
						if (h1 < limit) begin
							held_d[i] = h1;
						end else begin
							stable_d[i] = samp[i];
							held_d[i]   = '0;
							edge_d[i]   = 1'b1;
						end
					end
				end
				if (edge_d[0] && samp[0]) begin
					latch_d = 1'b1;
					event_d = 1'b1;
					if (count_q != '1) begin
						count_d = count_q + CNT_W'(1);
					end
				end
				for (int j = 0; j < NUM_OUTPUTS; j++) begin
					if (pulse_q[j] != '0) begin
						pulse_d[j] = pulse_q[j] - TICKS_W'(1);
					end
				end
			end
			CMD_PULSE: begin
				for (int j = 0; j < NUM_OUTPUTS; j++) begin
					if (32'(in_s1.pulse_channel) == j && in_s1.pulse_ticks != '0) begin
						pulse_d[j] = in_s1.pulse_ticks;
					end
				end
			end
			CMD_CLEAR: begin
				latch_d = 1'b0;
				count_d = '0;
			end
			CMD_ALL_OFF: begin
				for (int j = 0; j < NUM_OUTPUTS; j++) begin
					pulse_d[j] = '0;
				end
			end
			CMD_INIT: begin
				stable_d = samp;
				cand_d   = samp;
				for (int i = 0; i < NUM_INPUTS; i++) begin
					held_d[i] = '0;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int j = 0; j < NUM_OUTPUTS; j++) begin
			pulse_on[j] = (pulse_d[j] != '0);
		end
	end

	always_comb begin
		res_d                = '0;
		res_d.stable_levels  = stable_lo;
		res_d.edge_flags     = edge_lo;
		res_d.response_event = event_d;
		res_d.response_latch = latch_d;
		res_d.response_count = count_d;
		res_d.pulse_levels   = pulse_lo;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q   <= '0;
			stable_q <= '0;
			latch_q  <= 1'b0;
			count_q  <= '0;
			for (int i = 0; i < NUM_INPUTS; i++) begin
				held_q[i] <= '0;
			end
			for (int j = 0; j < NUM_OUTPUTS; j++) begin
				pulse_q[j] <= '0;
			end
		end else if (adv) begin
			cand_q   <= cand_d;
			stable_q <= stable_d;
			latch_q  <= latch_d;
			count_q  <= count_d;
			held_q   <= held_d;
			pulse_q  <= pulse_d;
		end
	end

	// checks
	`DIPT_ASSERT_NOW(a_count_needs_latch, count_q != '0, latch_q,
		"response count set without latch")
	`DIPT_ASSERT_NOW(a_event_is_rise, out_valid_q && res_q.response_event,
		res_q.edge_flags[0] && res_q.stable_levels[0], "response event without rising edge")
	`DIPT_ASSERT_NEXT(a_adv_loads_out, adv, out_valid_q, "advanced item lost")
	`DIPT_ASSERT_NEXT(a_all_off, adv && cmd_s1 == CMD_ALL_OFF,
		res_q.pulse_levels == '0, "pulses still running after all off")

endmodule
